FILE: rtl/core/srpc_pkg.sv
`default_nettype none
package srpc_pkg;

    localparam int SLOT_COUNT_DEF = 1024;
    localparam int FIELD_W        = 10;
    localparam int CFG_W          = 11;
    localparam int ENTRY_RST      = 1024;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_INIT_LEAF,
        CMD_INIT_START,
        CMD_INIT_DEC,
        CMD_RD_L,
        CMD_RD_R,
        CMD_WR_P,
        CMD_LOAD,
        CMD_RD_A,
        CMD_RD_B,
        CMD_CAP_B,
        CMD_WLEAF_A,
        CMD_WLEAF_B,
        CMD_Q_START,
        CMD_Q_LO,
        CMD_Q_HI
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t code;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic in_use;
        logic is_query;
        logic empty;
        logic leaf_last;
        logic parent_is_one;
        logic lo_lt_hi;
        logic out_busy;
    } stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/swap_and_range_permutation_check.sv
// Keeps a permutation of SLOT_COUNT slot values with min and max segment trees in two
// single-port-per-side memories of 2*SLOT_COUNT nodes. After reset a build pass fills the
// leaves with the identity and then computes every inner node; no request is taken until
// it ends. One request is processed at a time, and each node access costs a registered
// memory read. A swap rewrites both leaf-to-root paths, reading the left and right child
// and writing the parent at each level. A query walks up the tree one level at a time;
// a rejected request returns to idle with no result. A finished result waits in the output
// register while the block goes on with the next request; while it stalls, a newer result
// is held back and no request is taken.
`default_nettype none
module swap_and_range_permutation_check
    import srpc_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_opcode,
    input  wire logic [FIELD_W-1:0] s_first_index,
    input  wire logic [FIELD_W-1:0] s_second_index,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [FIELD_W-1:0]      m_range_min,
    output logic [FIELD_W-1:0]      m_range_max,
    output logic                    m_range_ok,
    input  wire logic               cfg_we,
    input  wire logic [CFG_W-1:0]   cfg_wdata
);

    cmd_t  cmd;
    stat_t stat;

    srpc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    srpc_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_opcode       (s_opcode),
        .s_first_index  (s_first_index),
        .s_second_index (s_second_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_range_min    (m_range_min),
        .m_range_max    (m_range_max),
        .m_range_ok     (m_range_ok),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

endmodule
`default_nettype wire

FILE: rtl/core/srpc_datapath.sv
`default_nettype none
module srpc_datapath
    import srpc_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cmd_t               cmd,
    output stat_t                   stat,
    input  wire logic               s_opcode,
    input  wire logic [FIELD_W-1:0] s_first_index,
    input  wire logic [FIELD_W-1:0] s_second_index,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [FIELD_W-1:0]      m_range_min,
    output logic [FIELD_W-1:0]      m_range_max,
    output logic                    m_range_ok,
    input  wire logic               cfg_we,
    input  wire logic [CFG_W-1:0]   cfg_wdata
);

    localparam int VW = $clog2(SLOT_COUNT);
    localparam int AW = $clog2(2 * SLOT_COUNT);
    localparam int NW = AW + 1;
    localparam int XW = VW + FIELD_W;

    logic [VW-1:0] min_mem [2*SLOT_COUNT];
    logic [VW-1:0] max_mem [2*SLOT_COUNT];

    logic               op_reg;
    logic [FIELD_W-1:0] a_reg, b_reg;
    logic [VW-1:0]      cnt_reg, cnt_next;
    logic [NW-1:0]      cur_reg, cur_next;
    logic [NW-1:0]      lo_reg, lo_next, hi_reg, hi_next;
    logic [VW-1:0]      mn_reg, mn_next, mx_reg, mx_next;
    logic [VW-1:0]      lmin_reg, lmax_reg, va_reg, vb_reg;
    logic [VW-1:0]      rmin_reg, rmax_reg;
    logic               pend_reg, pend_next;
    logic [CFG_W-1:0]   entry_reg;
    logic               mvalid_reg;
    logic [FIELD_W-1:0] omin_reg, omax_reg;
    logic               ook_reg;

    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [VW-1:0] wmin, wmax;
    logic [NW-1:0] parent, leaf_a, leaf_b, hdec;
    logic [XW-1:0] mn_ext, mx_ext;

    assign parent = cur_reg >> 1;
    assign leaf_a = NW'(SLOT_COUNT) + NW'(a_reg);
    assign leaf_b = NW'(SLOT_COUNT) + NW'(b_reg);
    assign hdec   = hi_reg[0] ? hi_reg - NW'(1) : hi_reg;
    assign mn_ext = XW'(mn_reg);
    assign mx_ext = XW'(mx_reg);

    always_comb begin
        stat.in_use = ({1'b0, a_reg} < entry_reg) && ({1'b0, b_reg} < entry_reg)
                      && (32'(a_reg) < SLOT_COUNT) && (32'(b_reg) < SLOT_COUNT);
        stat.is_query      = op_reg;
        stat.empty         = a_reg > b_reg;
        stat.leaf_last     = cnt_reg == VW'(SLOT_COUNT - 1);
        stat.parent_is_one = parent == NW'(1);
        stat.lo_lt_hi      = lo_reg < hi_reg;
        stat.out_busy      = mvalid_reg && !m_ready;
    end

    always_comb begin
        we        = 1'b0;
        re        = 1'b0;
        waddr     = '0;
        raddr     = '0;
        wmin      = '0;
        wmax      = '0;
        cnt_next  = cnt_reg;
        cur_next  = cur_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        pend_next = 1'b0;
        mn_next   = mn_reg;
        mx_next   = mx_reg;
        if (pend_reg) begin
            mn_next = (rmin_reg < mn_reg) ? rmin_reg : mn_reg;
            mx_next = (rmax_reg > mx_reg) ? rmax_reg : mx_reg;
        end
        case (cmd.code)
            CMD_INIT_LEAF: begin
                we       = 1'b1;
                waddr    = AW'(SLOT_COUNT) + AW'(cnt_reg);
                wmin     = cnt_reg;
                wmax     = cnt_reg;
                cnt_next = cnt_reg + VW'(1);
            end
            CMD_INIT_START: begin
                cur_next = NW'(2 * (SLOT_COUNT - 1));
            end
            CMD_INIT_DEC: begin
                cur_next = (cur_reg - NW'(1)) << 1;
            end
            CMD_RD_L: begin
                re    = 1'b1;
                raddr = AW'(cur_reg & ~NW'(1));
            end
            CMD_RD_R: begin
                re    = 1'b1;
                raddr = AW'(cur_reg | NW'(1));
            end
            CMD_WR_P: begin
                we       = 1'b1;
                waddr    = parent[AW-1:0];
                wmin     = (rmin_reg < lmin_reg) ? rmin_reg : lmin_reg;
                wmax     = (rmax_reg > lmax_reg) ? rmax_reg : lmax_reg;
                cur_next = parent;
            end
            CMD_RD_A: begin
                re    = 1'b1;
                raddr = leaf_a[AW-1:0];
            end
            CMD_RD_B: begin
                re    = 1'b1;
                raddr = leaf_b[AW-1:0];
            end
            CMD_WLEAF_A: begin
                we       = 1'b1;
                waddr    = leaf_a[AW-1:0];
                wmin     = vb_reg;
                wmax     = vb_reg;
                cur_next = leaf_a;
            end
            CMD_WLEAF_B: begin
                we       = 1'b1;
                waddr    = leaf_b[AW-1:0];
                wmin     = va_reg;
                wmax     = va_reg;
                cur_next = leaf_b;
            end
            CMD_Q_START: begin
                lo_next = leaf_a;
                hi_next = leaf_b + NW'(1);
                mn_next = '1;
                mx_next = '0;
            end
            CMD_Q_LO: begin
                if (lo_reg[0]) begin
                    re        = 1'b1;
                    raddr     = lo_reg[AW-1:0];
                    lo_next   = lo_reg + NW'(1);
                    pend_next = 1'b1;
                end
            end
            CMD_Q_HI: begin
                if (hi_reg[0]) begin
                    re        = 1'b1;
                    raddr     = hdec[AW-1:0];
                    pend_next = 1'b1;
                end
                hi_next = hdec >> 1;
                lo_next = lo_reg >> 1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            min_mem[waddr] <= wmin;
            max_mem[waddr] <= wmax;
        end
        if (re) begin
            rmin_reg <= min_mem[raddr];
            rmax_reg <= max_mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mn_reg  <= mn_next;
        mx_reg  <= mx_next;
        if (cmd.code == CMD_INIT_START || !aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        if (cmd.code == CMD_LOAD) begin
            op_reg <= s_opcode;
            a_reg  <= s_first_index;
            b_reg  <= s_second_index;
        end
        if (cmd.code == CMD_RD_R) begin
            lmin_reg <= rmin_reg;
            lmax_reg <= rmax_reg;
        end
        if (cmd.code == CMD_RD_B) begin
            va_reg <= rmin_reg;
        end
        if (cmd.code == CMD_CAP_B) begin
            vb_reg <= rmin_reg;
        end
        if (cmd.out_load) begin
            if (a_reg > b_reg) begin
                omin_reg <= '1;
                omax_reg <= '0;
                ook_reg  <= 1'b0;
            end else begin
                omin_reg <= mn_ext[FIELD_W-1:0];
                omax_reg <= mx_ext[FIELD_W-1:0];
                ook_reg  <= (mn_ext == XW'(a_reg)) && (mx_ext == XW'(b_reg));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
            entry_reg  <= CFG_W'(ENTRY_RST);
        end else begin
            pend_reg <= pend_next;
            if (cfg_we) begin
                entry_reg <= cfg_wdata;
            end
            if (cmd.out_load) begin
                mvalid_reg <= 1'b1;
            end else if (m_ready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = mvalid_reg;
    assign m_range_min = omin_reg;
    assign m_range_max = omax_reg;
    assign m_range_ok  = ook_reg;

endmodule
`default_nettype wire

FILE: rtl/core/srpc_ctrl.sv
`default_nettype none
module srpc_ctrl
    import srpc_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    typedef enum logic [13:0] {
        ST_INIT_LEAF  = 14'b00000000000001,
        ST_INIT_START = 14'b00000000000010,
        ST_INIT_DEC   = 14'b00000000000100,
        ST_RD_L       = 14'b00000000001000,
        ST_RD_R       = 14'b00000000010000,
        ST_WR_P       = 14'b00000000100000,
        ST_IDLE       = 14'b00000001000000,
        ST_DECIDE     = 14'b00000010000000,
        ST_RD_A       = 14'b00000100000000,
        ST_RD_B       = 14'b00001000000000,
        ST_CAP_B      = 14'b00010000000000,
        ST_WLEAF      = 14'b00100000000000,
        ST_Q_LO       = 14'b01000000000000,
        ST_Q_HI       = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   init_reg, init_next;
    logic   second_reg, second_next;
    logic   out_reg, out_next;

    always_comb begin
        state_next   = state_reg;
        init_next    = init_reg;
        second_next  = second_reg;
        out_next     = 1'b0;
        cmd.code     = CMD_NONE;
        cmd.out_load = 1'b0;
        s_ready      = 1'b0;
        case (state_reg)
            ST_INIT_LEAF: begin
                cmd.code = CMD_INIT_LEAF;
                if (stat.leaf_last) begin
                    state_next = ST_INIT_START;
                end
            end
            ST_INIT_START: begin
                cmd.code   = CMD_INIT_START;
                init_next  = 1'b1;
                state_next = ST_RD_L;
            end
            ST_INIT_DEC: begin
                cmd.code   = CMD_INIT_DEC;
                state_next = ST_RD_L;
            end
            ST_RD_L: begin
                cmd.code   = CMD_RD_L;
                state_next = ST_RD_R;
            end
            ST_RD_R: begin
                cmd.code   = CMD_RD_R;
                state_next = ST_WR_P;
            end
            ST_WR_P: begin
                cmd.code = CMD_WR_P;
                if (stat.parent_is_one) begin
                    if (init_reg) begin
                        init_next  = 1'b0;
                        state_next = ST_IDLE;
                    end else if (!second_reg) begin
                        second_next = 1'b1;
                        state_next  = ST_WLEAF;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else if (init_reg) begin
                    state_next = ST_INIT_DEC;
                end else begin
                    state_next = ST_RD_L;
                end
            end
            ST_IDLE: begin
                if (out_reg) begin
                    if (!stat.out_busy) begin
                        cmd.out_load = 1'b1;
                    end else begin
                        out_next = 1'b1;
                    end
                end else begin
                    s_ready = 1'b1;
                    if (s_valid) begin
                        cmd.code   = CMD_LOAD;
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE: begin
                second_next = 1'b0;
                if (!stat.in_use) begin
                    state_next = ST_IDLE;
                end else if (!stat.is_query) begin
                    state_next = ST_RD_A;
                end else if (stat.empty) begin
                    out_next   = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cmd.code   = CMD_Q_START;
                    state_next = ST_Q_LO;
                end
            end
            ST_RD_A: begin
                cmd.code   = CMD_RD_A;
                state_next = ST_RD_B;
            end
            ST_RD_B: begin
                cmd.code   = CMD_RD_B;
                state_next = ST_CAP_B;
            end
            ST_CAP_B: begin
                cmd.code   = CMD_CAP_B;
                state_next = ST_WLEAF;
            end
            ST_WLEAF: begin
                cmd.code   = second_reg ? CMD_WLEAF_B : CMD_WLEAF_A;
                state_next = ST_RD_L;
            end
            ST_Q_LO: begin
                if (stat.lo_lt_hi) begin
                    cmd.code   = CMD_Q_LO;
                    state_next = ST_Q_HI;
                end else begin
                    out_next   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_Q_HI: begin
                cmd.code   = CMD_Q_HI;
                state_next = ST_Q_LO;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_INIT_LEAF;
            init_reg   <= 1'b0;
            second_reg <= 1'b0;
            out_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            init_reg   <= init_next;
            second_reg <= second_next;
            out_reg    <= out_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/srpc_check.sv
`default_nettype none
module srpc_check
    import srpc_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               s_opcode,
    input wire logic [FIELD_W-1:0] s_first_index,
    input wire logic [FIELD_W-1:0] s_second_index,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [FIELD_W-1:0] m_range_min,
    input wire logic [FIELD_W-1:0] m_range_max,
    input wire logic               m_range_ok,
    input wire logic               cfg_we,
    input wire logic [CFG_W-1:0]   cfg_wdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_range_min) && $stable(m_range_max)
        && $stable(m_range_ok))
        else $error("Result changed while stalled.");

    a_build_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("Request taken before the tree build finished.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Request taken while another was in progress.");

    a_ok_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_range_ok |-> m_range_min <= m_range_max)
        else $error("Range flagged as complete with minimum above maximum.");

endmodule

bind swap_and_range_permutation_check srpc_check u_check (.*);
`default_nettype wire

FILE: dv/tb_swap_and_range_permutation_check.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_swap_and_range_permutation_check;
    import srpc_pkg::*;

    localparam int SLOTS = 1024;

    typedef struct {
        logic               opcode;
        logic [FIELD_W-1:0] first;
        logic [FIELD_W-1:0] second;
    } request_t;

    typedef struct {
        logic [FIELD_W-1:0] rmin;
        logic [FIELD_W-1:0] rmax;
        logic               ok;
    } answer_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_opcode = 1'b0;
    logic [FIELD_W-1:0] s_first_index = '0;
    logic [FIELD_W-1:0] s_second_index = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [FIELD_W-1:0] m_range_min;
    logic [FIELD_W-1:0] m_range_max;
    logic               m_range_ok;
    logic               cfg_we = 1'b0;
    logic [CFG_W-1:0]   cfg_wdata = '0;

    request_t pending_requests[$];
    answer_t  expected_answers[$];
    logic [FIELD_W-1:0] slot_copy[SLOTS];
    int unsigned entry_limit;
    int errors = 0;
    int gap_left = 0;
    int burst_left = 0;
    int stall_hold = 0;
    bit hold_sender = 0;
    bit in_taken = 0;

    swap_and_range_permutation_check i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_first_index(s_first_index), .s_second_index(s_second_index),
        .m_valid(m_valid), .m_ready(m_ready), .m_range_min(m_range_min),
        .m_range_max(m_range_max), .m_range_ok(m_range_ok),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    task automatic predict_request(input request_t r);
        int unsigned a, b, mn, mx, lim;
        logic [FIELD_W-1:0] t;
        answer_t ans;
        a = 32'(r.first);
        b = 32'(r.second);
        lim = (entry_limit < SLOTS) ? entry_limit : SLOTS;
        if (a >= lim || b >= lim) return;
        if (!r.opcode) begin
            t = slot_copy[a];
            slot_copy[a] = slot_copy[b];
            slot_copy[b] = t;
            return;
        end
        if (a > b) begin
            ans.rmin = 10'h3FF;
            ans.rmax = '0;
            ans.ok = 1'b0;
        end else begin
            mn = 32'hFFFF_FFFF;
            mx = 0;
            for (int i = a; i <= b; i++) begin
                if (32'(slot_copy[i]) < mn) mn = 32'(slot_copy[i]);
                if (32'(slot_copy[i]) > mx) mx = 32'(slot_copy[i]);
            end
            ans.rmin = mn[FIELD_W-1:0];
            ans.rmax = mx[FIELD_W-1:0];
            ans.ok = (mn == a && mx == b);
        end
        expected_answers = {expected_answers, ans};
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task automatic add_request(input logic op, input int a, input int b);
        request_t r;
        r.opcode = op;
        r.first = a[FIELD_W-1:0];
        r.second = b[FIELD_W-1:0];
        pending_requests = {pending_requests, r};
    endtask

    task automatic drain_and_wait();
        while (pending_requests.size() != 0 || s_valid || expected_answers.size() != 0)
            @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    task automatic write_limit(input int value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value[CFG_W-1:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
        entry_limit = value;
    endtask

    task automatic random_phase(input int count, input int lim);
        int a, b, span;
        for (int n = 0; n < count; n++) begin
            span = (lim > 1) ? lim - 1 : 0;
            if ($urandom_range(0, 19) == 0) begin
                add_request(1'($urandom_range(0, 1)), $urandom_range(0, 1023),
                            $urandom_range(0, 1023));
            end else if ($urandom_range(0, 1)) begin
                add_request(1'b0, $urandom_range(0, span), $urandom_range(0, span));
            end else begin
                a = $urandom_range(0, span);
                b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, span)
                    : a + $urandom_range(0, 40);
                if (b > span) b = span;
                add_request(1'b1, a, b);
            end
        end
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (hold_sender || pending_requests.size() == 0) begin
                s_valid <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else begin
                request_t r;
                r = pending_requests.pop_front();
                s_valid <= 1'b1;
                s_opcode <= r.opcode;
                s_first_index <= r.first;
                s_second_index <= r.second;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (stall_hold > 0) begin
            stall_hold--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        answer_t want;
        request_t r;
        in_taken = aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                r.opcode = s_opcode;
                r.first = s_first_index;
                r.second = s_second_index;
                predict_request(r);
            end
            if (m_valid && m_ready) begin
                if (expected_answers.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = expected_answers.pop_front();
                    if (m_range_min !== want.rmin)
                        report_mismatch("range_min", int'(m_range_min), int'(want.rmin));
                    if (m_range_max !== want.rmax)
                        report_mismatch("range_max", int'(m_range_max), int'(want.rmax));
                    if (m_range_ok !== want.ok)
                        report_mismatch("range_ok", int'(m_range_ok), int'(want.ok));
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("tb_swap_and_range_permutation_check failed");
        $finish;
    end

    initial begin
        int settings[5];
        for (int i = 0; i < SLOTS; i++) slot_copy[i] = i[FIELD_W-1:0];
        entry_limit = ENTRY_RST;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        add_request(1'b1, 0, 1023);
        add_request(1'b1, 0, 0);
        add_request(1'b1, 1023, 1023);
        add_request(1'b1, 5, 3);
        add_request(1'b1, 1023, 0);
        add_request(1'b0, 7, 7);
        add_request(1'b1, 7, 7);
        add_request(1'b0, 0, 1023);
        add_request(1'b1, 0, 1023);
        add_request(1'b1, 0, 0);
        add_request(1'b1, 1, 1022);
        add_request(1'b0, 341, 682);
        add_request(1'b1, 300, 700);
        add_request(1'b1, 341, 341);
        add_request(1'b0, 0, 1023);
        add_request(1'b1, 0, 1023);
        add_request(1'b0, 682, 341);
        add_request(1'b1, 341, 682);
        drain_and_wait();

        write_limit(0);
        add_request(1'b1, 0, 0);
        add_request(1'b0, 0, 1);
        drain_and_wait();
        write_limit(1);
        add_request(1'b1, 0, 0);
        add_request(1'b1, 0, 1);
        add_request(1'b0, 0, 0);
        drain_and_wait();
        write_limit(2047);
        add_request(1'b1, 1023, 1023);
        add_request(1'b0, 2, 1023);
        add_request(1'b1, 0, 1023);
        drain_and_wait();

        random_phase(150, 1024);
        stall_hold = 400;
        drain_and_wait();

        settings = '{16, 1024, 3, 700, 64};
        foreach (settings[k]) begin
            write_limit(settings[k]);
            random_phase(130, settings[k] + 2);
            if (k == 2) begin
                while (pending_requests.size() > 60) @(posedge aclk);
                hold_sender = 1;
                while (s_valid || expected_answers.size() != 0) @(posedge aclk);
                hold_sender = 0;
            end
            drain_and_wait();
        end

        if (errors == 0) begin
            $display("tb_swap_and_range_permutation_check passed");
        end else begin
            $display("tb_swap_and_range_permutation_check failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: swap_and_range_permutation_check.f
rtl/core/srpc_pkg.sv
rtl/core/srpc_datapath.sv
rtl/core/srpc_ctrl.sv
rtl/core/swap_and_range_permutation_check.sv
rtl/core/srpc_check.sv
dv/tb_swap_and_range_permutation_check.sv
